// File: rtl/indexed_list_buffer_assert.svh
// Assertion macros for the indexed list buffer RTL, included by the sequencer (ilb_ctrl).
`ifndef INDEXED_LIST_BUFFER_ASSERT_SVH
`define INDEXED_LIST_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define ILB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("indexed_list_buffer: check failed");
`define ILB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("indexed_list_buffer: check failed");
`else
`define ILB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ilb_pkg.sv
// Types and constants of the indexed list buffer.
package ilb_pkg;

	localparam int CAPACITY  = 64;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_DROP   = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_READ   = 3'd4,
		OP_WRITE  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_REM_RD,
		S_REM_WR,
		S_RD_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                        op;
		logic [ADDR_W-1:0]          index;
		logic signed [WORD_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] read_value;
		logic [CNT_W-1:0]            size;
		logic                        empty_res;
		status_t                     status;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [WORD_BITS-1:0]  wdata;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage

// File: rtl/ilb_mem.sv
// Entry storage: one write port, one registered read port.
module ilb_mem (
	input  logic                           clk,
	input  ilb_pkg::mem_req_t              req,
	output logic [ilb_pkg::WORD_BITS-1:0]  rdata
);

	logic [ilb_pkg::WORD_BITS-1:0] mem [ilb_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

// File: rtl/ilb_ctrl.sv
// Sequencer: decodes an item and moves entries one at a time through the memory.
`include "indexed_list_buffer_assert.svh"

module ilb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  ilb_pkg::cmd_t                  cmd,
	output logic                           busy,
	output logic                           done,
	output ilb_pkg::res_t                  result,
	output ilb_pkg::mem_req_t              mem_req,
	input  logic [ilb_pkg::WORD_BITS-1:0]  rdata
);

	localparam int CNT_W  = ilb_pkg::CNT_W;
	localparam int ADDR_W = ilb_pkg::ADDR_W;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(ilb_pkg::CAPACITY);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	ilb_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [ilb_pkg::WORD_BITS-1:0] val_q, val_d;
	logic [ilb_pkg::WORD_BITS-1:0] rdval_q, rdval_d;
	ilb_pkg::status_t status_q, status_d;

	logic [CNT_W-1:0] in_idx;
	logic             in_range;
	logic             is_full;
	logic             is_empty;
	// shared pointer unit: one add/subtract and one compare
	logic             step_up;
	logic [CNT_W-1:0] step_sum;
	logic [CNT_W-1:0] cmp_a, cmp_b;
	logic             cmp_eq;

	assign in_idx   = {1'b0, cmd.index};
	assign in_range = in_idx < count_q;
	assign is_full  = count_q == CAP;
	assign is_empty = count_q == '0;

	assign step_sum = step_up ? ptr_q + ONE : ptr_q - ONE;
	assign cmp_eq   = cmp_a == cmp_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		rdval_q  <= rdval_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ptr_d    = ptr_q;
		idx_d    = idx_q;
		val_d    = val_q;
		rdval_d  = rdval_q;
		status_d = status_q;
		step_up  = 1'b0;
		cmp_a    = ptr_q;
		cmp_b    = idx_q;
		mem_req  = '{we: 1'b0, waddr: ptr_q[ADDR_W-1:0], wdata: rdata,
			raddr: ptr_q[ADDR_W-1:0]};
		unique case (state_q)
			ilb_pkg::S_IDLE: begin
				if (start) begin
					idx_d    = in_idx;
					val_d    = cmd.value;
					rdval_d  = '0;
					status_d = ilb_pkg::ST_OK;
					state_d  = ilb_pkg::S_DONE;
					unique case (cmd.op)
						ilb_pkg::OP_APPEND, ilb_pkg::OP_INSERT: begin
							if (is_full) begin
								status_d = ilb_pkg::ST_FULL;
							end else if (cmd.op == ilb_pkg::OP_INSERT && in_range) begin
								ptr_d   = count_q;
								state_d = ilb_pkg::S_INS_RD;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q[ADDR_W-1:0];
								mem_req.wdata = cmd.value;
								count_d       = count_q + ONE;
							end
						end
						ilb_pkg::OP_DROP, ilb_pkg::OP_REMOVE: begin
							if (cmd.op == ilb_pkg::OP_REMOVE && in_range) begin
								ptr_d   = in_idx;
								state_d = ilb_pkg::S_REM_RD;
							end else if (is_empty) begin
								status_d = ilb_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - ONE;
							end
						end
						ilb_pkg::OP_READ: begin
							if (in_range) begin
								mem_req.raddr = cmd.index;
								state_d       = ilb_pkg::S_RD_WAIT;
							end else begin
								status_d = ilb_pkg::ST_RANGE;
							end
						end
						ilb_pkg::OP_WRITE: begin
							if (in_range) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = cmd.index;
								mem_req.wdata = cmd.value;
							end else begin
								status_d = ilb_pkg::ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ilb_pkg::S_INS_RD: begin
				// walk down from the tail; the gap reached the index: drop the item in
				step_up = 1'b0;
				if (cmp_eq) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q[ADDR_W-1:0];
					mem_req.wdata = val_q;
					count_d       = count_q + ONE;
					state_d       = ilb_pkg::S_DONE;
				end else begin
					mem_req.raddr = step_sum[ADDR_W-1:0];
					state_d       = ilb_pkg::S_INS_WR;
				end
			end
			ilb_pkg::S_INS_WR: begin
				step_up     = 1'b0;
				mem_req.we  = 1'b1;
				ptr_d       = step_sum;
				state_d     = ilb_pkg::S_INS_RD;
			end
			ilb_pkg::S_REM_RD: begin
				step_up = 1'b1;
				cmp_a   = step_sum;
				cmp_b   = count_q;
				if (cmp_eq) begin
					count_d = count_q - ONE;
					state_d = ilb_pkg::S_DONE;
				end else begin
					mem_req.raddr = step_sum[ADDR_W-1:0];
					state_d       = ilb_pkg::S_REM_WR;
				end
			end
			ilb_pkg::S_REM_WR: begin
				step_up    = 1'b1;
				mem_req.we = 1'b1;
				ptr_d      = step_sum;
				state_d    = ilb_pkg::S_REM_RD;
			end
			ilb_pkg::S_RD_WAIT: begin
				rdval_d = rdata;
				state_d = ilb_pkg::S_DONE;
			end
			ilb_pkg::S_DONE: begin
				state_d = ilb_pkg::S_IDLE;
			end
			default: begin
				state_d = ilb_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = state_q != ilb_pkg::S_IDLE;
	assign done = state_q == ilb_pkg::S_DONE;

	assign result.read_value = rdval_q;
	assign result.size       = count_q;
	assign result.empty_res  = is_empty;
	assign result.status     = status_q;

	`ILB_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP)
	`ILB_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ILB_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	`ILB_ASSERT_NOW(a_full_status, clk, arst_n,
		done && status_q == ilb_pkg::ST_FULL, count_q == CAP)
	`ILB_ASSERT_NOW(a_ins_ptr, clk, arst_n,
		state_q == ilb_pkg::S_INS_RD || state_q == ilb_pkg::S_INS_WR,
		ptr_q <= count_q && ptr_q >= idx_q)

endmodule

// File: rtl/indexed_list_buffer.sv
// Top level of the indexed list buffer.
//
// An ordered list of signed words with room for CAPACITY entries.
// Command channel: an item (op, index, value) is taken at a rising edge
// with start high and busy low; busy stays high until the result is out.
// Result channel: done is high for exactly one cycle while result holds
// read_value, size, empty_res and status; the receiver cannot stall it.
// Sequence from the accepting edge to the cycle done is high:
//   append, drop, write, unused codes, refused or out-of-range items,
//   and insert or remove at or past the end: straight to done
//   read: a registered memory read (S_RD_WAIT), then done
//   insert at index i below size, list not full: size-i entries moved up, then the item written, then done
//   remove at index i below size: size-i-1 entries moved down, then done
// busy drops the cycle after done, so the next item can be taken in the
// cycle after the result. Insert and remove move one entry at a time, a read
// then a write, through the read and write ports of the entry memory.
// Reset (arst_n low) empties the list; entry contents are not cleared,
// and no item is accepted during reset.
module indexed_list_buffer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ilb_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            done,
	output ilb_pkg::res_t   result
);

	ilb_pkg::mem_req_t             mem_req;
	logic [ilb_pkg::WORD_BITS-1:0] rdata;

	ilb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	ilb_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

endmodule

// File: dv/tb_indexed_list_buffer.sv
// Self-checking testbench for the indexed list buffer: directed, fill/drain and random requests.
module tb_indexed_list_buffer;
	import ilb_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	res_t result;

	indexed_list_buffer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// shadow copy of the list contents
	logic signed [WORD_BITS-1:0] list_words [CAPACITY];
	int list_len = 0;
	int peak_len = 0;

	res_t pending_results [$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int status_hits [4] = '{0, 0, 0, 0};
	int unsigned cycle_count = 0;
	bit no_gaps = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	function automatic status_t push_word(input logic signed [WORD_BITS-1:0] w);
		if (list_len >= CAPACITY)
			return ST_FULL;
		list_words[list_len] = w;
		list_len++;
		return ST_OK;
	endfunction

	function automatic status_t pop_word();
		if (list_len == 0)
			return ST_EMPTY;
		list_len--;
		return ST_OK;
	endfunction

	// updates the shadow list and returns the result the request must produce
	function automatic res_t apply_request(input cmd_t c);
		res_t r;
		int pos;
		pos = c.index;
		r = '0;
		r.status = ST_OK;
		case (c.op)
			OP_APPEND: r.status = push_word(c.value);
			OP_DROP: r.status = pop_word();
			OP_INSERT: begin
				if (pos >= list_len)
					r.status = push_word(c.value);
				else if (list_len >= CAPACITY)
					r.status = ST_FULL;
				else begin
					for (int i = list_len; i > pos; i--)
						list_words[i] = list_words[i - 1];
					list_words[pos] = c.value;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (pos >= list_len)
					r.status = pop_word();
				else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			OP_READ: begin
				if (pos < list_len)
					r.read_value = list_words[pos];
				else
					r.status = ST_RANGE;
			end
			OP_WRITE: begin
				if (pos < list_len)
					list_words[pos] = c.value;
				else
					r.status = ST_RANGE;
			end
			default: ;
		endcase
		r.size = CNT_W'(list_len);
		r.empty_res = (list_len == 0);
		if (list_len > peak_len)
			peak_len = list_len;
		return r;
	endfunction

	// one request through the start/busy handshake
	task automatic issue(input logic [2:0] code, input int idx, input logic [31:0] val);
		cmd_t c;
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.op = op_t'(code);
		c.index = ADDR_W'(idx);
		c.value = val;
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_request(c));
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			results_seen++;
			status_hits[result.status]++;
			if (pending_results.size() == 0)
				flag("result with no request pending");
			else begin
				want = pending_results.pop_front();
				if (result.read_value !== want.read_value)
					flag($sformatf("read_value %0d, expected %0d", result.read_value,
						want.read_value));
				if (result.size !== want.size)
					flag($sformatf("size %0d, expected %0d", result.size, want.size));
				if (result.empty_res !== want.empty_res)
					flag($sformatf("empty_res %0b, expected %0b", result.empty_res,
						want.empty_res));
				if (result.status !== want.status)
					flag($sformatf("status %0d, expected %0d", result.status, want.status));
			end
		end
	end

	function automatic int pick_index();
		if (list_len == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, CAPACITY - 1);
		return $urandom_range(0, list_len - 1);
	endfunction

	// corner cases on an empty and a short list
	task automatic test_directed();
		issue(OP_READ, 0, $urandom);
		issue(OP_DROP, 0, $urandom);
		issue(OP_REMOVE, 5, $urandom);
		issue(OP_WRITE, 0, $urandom);
		issue(OP_APPEND, 0, 32'h7FFF_FFFF);
		issue(OP_APPEND, 0, 32'h8000_0000);
		issue(OP_INSERT, 0, 32'hFFFF_FFFF);
		issue(OP_INSERT, 1, 32'h1234_5678);
		issue(OP_INSERT, 63, 32'h0000_0000);
		for (int i = 0; i < 5; i++)
			issue(OP_READ, i, $urandom);
		issue(OP_READ, 63, $urandom);
		issue(OP_WRITE, 2, 32'hA5A5_A5A5);
		issue(OP_WRITE, 5, $urandom);
		issue(OP_READ, 2, $urandom);
		issue(OP_SPARE_A, 1, $urandom);
		issue(OP_SPARE_B, 0, $urandom);
		issue(OP_REMOVE, 1, $urandom);
		issue(OP_REMOVE, 50, $urandom);
		issue(OP_DROP, 0, $urandom);
		issue(OP_READ, 0, $urandom);
		settle();
	endtask

	// fill to capacity, poke the full list, then empty it again
	task automatic test_fill_drain();
		while (list_len < CAPACITY) begin
			if ($urandom_range(0, 1))
				issue(OP_APPEND, $urandom_range(0, 63), $urandom);
			else
				issue(OP_INSERT, pick_index(), $urandom);
		end
		issue(OP_APPEND, 0, $urandom);
		issue(OP_INSERT, 0, $urandom);
		issue(OP_INSERT, 63, $urandom);
		issue(OP_WRITE, 63, $urandom);
		issue(OP_READ, 63, $urandom);
		issue(OP_READ, 0, $urandom);
		issue(OP_REMOVE, 63, $urandom);
		issue(OP_INSERT, 63, $urandom);
		issue(OP_INSERT, 0, $urandom);
		for (int i = 0; i < 8; i++)
			issue(OP_READ, pick_index(), $urandom);
		while (list_len > 0) begin
			if ($urandom_range(0, 3) == 0)
				issue(OP_DROP, $urandom_range(0, 63), $urandom);
			else
				issue(OP_REMOVE, pick_index(), $urandom);
		end
		issue(OP_DROP, 0, $urandom);
		issue(OP_REMOVE, 0, $urandom);
		settle();
	endtask

	// segments that lean toward growing, shrinking or accessing the list
	task automatic test_random(input int n_items);
		int lean;
		int roll;
		int sent;
		logic [2:0] code;
		sent = 0;
		while (sent < n_items) begin
			lean = $urandom_range(0, 2);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 40 && sent < n_items; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					code = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
				else if (lean == 0)
					code = (roll < 40) ? OP_APPEND : (roll < 70) ? OP_INSERT :
						(roll < 80) ? OP_REMOVE : (roll < 90) ? OP_READ : OP_WRITE;
				else if (lean == 1)
					code = (roll < 35) ? OP_DROP : (roll < 70) ? OP_REMOVE :
						(roll < 80) ? OP_APPEND : (roll < 90) ? OP_READ : OP_INSERT;
				else
					code = (roll < 45) ? OP_READ : (roll < 80) ? OP_WRITE :
						(roll < 88) ? OP_INSERT : (roll < 94) ? OP_REMOVE :
						(roll < 97) ? OP_APPEND : OP_DROP;
				issue(code, pick_index(), $urandom);
				sent++;
			end
		end
		no_gaps = 1'b0;
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain();
		test_random(320);
		if (pending_results.size() != 0)
			flag($sformatf("%0d results never arrived", pending_results.size()));
		$display("covered %0d items, %0d results, peak length %0d of %0d", items_sent,
			results_seen, peak_len, CAPACITY);
		$display("status counts: ok %0d, full %0d, empty %0d, range %0d", status_hits[0],
			status_hits[1], status_hits[2], status_hits[3]);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
